// ===== src/pwws_pkg.sv =====
// Shared types, widths, register codes and saturation helpers for the PID core.
// No dependencies; every other file of the core uses this package.
package pwws_pkg;

   // Field widths fixed by the controller interface.
   localparam int SampleWidth = 16;
   localparam int DriveWidth  = 32;
   localparam int LimitWidth  = 31;
   localparam int IndexWidth  = 3;
   localparam int CsrWidth    = 31;

   // Configuration register indexes.
   typedef enum logic [IndexWidth-1:0] {
      REG_PROP_GAIN   = 3'd0,
      REG_INTEG_GAIN  = 3'd1,
      REG_DERIV_GAIN  = 3'd2,
      REG_SETTLE_BAND = 3'd3,
      REG_SLEW_STEP   = 3'd4,
      REG_INTEG_LIMIT = 3'd5,
      REG_INTEG_ZONE  = 3'd6,
      REG_OUT_LIMIT   = 3'd7
   } reg_index_type;

   // Item function codes.
   typedef enum logic {
      FUNC_RUN   = 1'b0,
      FUNC_CLEAR = 1'b1
   } func_type;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic signed [SampleWidth-1:0] prop_gain;
      logic signed [SampleWidth-1:0] integ_gain;
      logic signed [SampleWidth-1:0] deriv_gain;
      logic        [SampleWidth-1:0] settle_band;
      logic        [LimitWidth-1:0]  slew_step;
      logic        [LimitWidth-1:0]  integ_limit;
      logic        [SampleWidth-1:0] integ_zone;
      logic        [LimitWidth-1:0]  out_limit;
   } cfg_type;

   // Saturate a wide signed value to the 32-bit signed range.
   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > $signed(50'h0_7FFF_FFFF)) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -$signed(50'h0_8000_0000)) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Clamp to +-lim; a zero limit leaves the value alone.
   function automatic logic signed [32:0] clamp_mag(input logic signed [32:0] v,
                                                    input logic [LimitWidth-1:0] lim);
      logic signed [32:0] hi;
      logic signed [32:0] r;
      hi = $signed({2'b00, lim});
      r  = v;
      if (lim != '0) begin
         if (v > hi) begin
            r = hi;
         end else if (v < -hi) begin
            r = -hi;
         end
      end
      return r;
   endfunction

endpackage

// ===== src/pwws_req_if.sv =====
// Input channel of the PID core: valid/ready handshake with the sample payload.
// Depends on pwws_pkg for field widths.
interface pwws_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   func;
   logic signed [pwws_pkg::SampleWidth-1:0] setpoint;
   logic signed [pwws_pkg::SampleWidth-1:0] actual;

   modport source (output valid, func, setpoint, actual, input ready);
   modport sink   (input valid, func, setpoint, actual, output ready);
endinterface

// ===== src/pwws_rsp_if.sv =====
// Result channel of the PID core: valid/ready handshake with drive and settled.
// Depends on pwws_pkg for field widths.
interface pwws_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [pwws_pkg::DriveWidth-1:0] drive;
   logic                                  settled;

   modport source (output valid, drive, settled, input ready);
   modport sink   (input valid, drive, settled, output ready);
endinterface

// ===== src/pwws_csr.sv =====
// Configuration register file of the PID core, written through a plain write port.
// Depends on pwws_pkg for the register codes and the configuration struct.
module pwws_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [pwws_pkg::IndexWidth-1:0]   csr_index,
   input  logic [pwws_pkg::CsrWidth-1:0]     csr_wdata,
   output pwws_pkg::cfg_type                 cfg
);

   pwws_pkg::cfg_type cfg_ff;
   pwws_pkg::cfg_type cfg_in;

   // Decode the write into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (pwws_pkg::reg_index_type'(csr_index))
            pwws_pkg::REG_PROP_GAIN:   cfg_in.prop_gain   = $signed(csr_wdata[15:0]);
            pwws_pkg::REG_INTEG_GAIN:  cfg_in.integ_gain  = $signed(csr_wdata[15:0]);
            pwws_pkg::REG_DERIV_GAIN:  cfg_in.deriv_gain  = $signed(csr_wdata[15:0]);
            pwws_pkg::REG_SETTLE_BAND: cfg_in.settle_band = csr_wdata[15:0];
            pwws_pkg::REG_SLEW_STEP:   cfg_in.slew_step   = csr_wdata;
            pwws_pkg::REG_INTEG_LIMIT: cfg_in.integ_limit = csr_wdata;
            pwws_pkg::REG_INTEG_ZONE:  cfg_in.integ_zone  = csr_wdata[15:0];
            pwws_pkg::REG_OUT_LIMIT:   cfg_in.out_limit   = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // Register storage; proportional gain comes out of reset at unity.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{prop_gain: 16'sd256, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/pwws_datapath.sv =====
// Single-pass PID arithmetic and controller state (integral, last error, last drive).
// Depends on pwws_pkg for widths, the configuration struct and saturation helpers.
module pwws_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pwws_pkg::cfg_type                       cfg,
   input  logic                                    step,
   input  logic                                    func,
   input  logic signed [pwws_pkg::SampleWidth-1:0] setpoint,
   input  logic signed [pwws_pkg::SampleWidth-1:0] actual,
   output logic signed [pwws_pkg::DriveWidth-1:0]  drive,
   output logic                                    settled,
   output logic signed [pwws_pkg::DriveWidth-1:0]  integ_sum
);

   // Controller state.
   logic signed [31:0] integ_ff, integ_in;
   logic signed [15:0] last_err_ff;
   logic               have_last_ff;
   logic signed [31:0] last_drive_ff, last_drive_in;

   logic signed [16:0] diff;
   logic signed [15:0] err;
   logic        [15:0] aerr;
   logic signed [16:0] der;
   logic               in_zone;
   logic signed [31:0] isum_add;
   logic signed [32:0] isum_a33;
   logic signed [31:0] isum_a;
   logic signed [31:0] isum_b_sat;
   logic signed [32:0] isum_b33;
   logic signed [31:0] isum_b;
   logic signed [31:0] prod_p;
   logic signed [32:0] prod_d;
   logic signed [47:0] prod_ia;
   logic signed [47:0] prod_ib;
   logic signed [49:0] sum_a;
   logic signed [49:0] sum_b;
   logic signed [31:0] drive_a;
   logic signed [31:0] drive_b;
   logic signed [32:0] olim;
   logic               over;
   logic signed [32:0] drive_b33;
   logic signed [31:0] drive_lim;
   logic signed [32:0] slew33;
   logic signed [32:0] slew_lo;
   logic signed [32:0] slew_hi;
   logic signed [32:0] drive_sl;
   logic signed [31:0] drive_run;
   logic               is_clear;

   assign is_clear = (pwws_pkg::func_type'(func) == pwws_pkg::FUNC_CLEAR);

   // Error, saturated to 16 bits, and its magnitude.
   assign diff = 17'(setpoint) - 17'(actual);
   always_comb begin
      if (diff > 17'sd32767) begin
         err = 16'sh7FFF;
      end else if (diff < -17'sd32768) begin
         err = 16'sh8000;
      end else begin
         err = diff[15:0];
      end
   end
   assign aerr    = err[15] ? 16'(-17'(err)) : err;
   assign settled = (aerr < cfg.settle_band);

   // Derivative term is zero until a previous error exists.
   assign der = have_last_ff ? (17'(err) - 17'(last_err_ff)) : 17'sd0;

   // Integral update with zone and clamp, plus the back-calculated candidate.
   assign in_zone  = (cfg.integ_zone == '0) || (aerr <= cfg.integ_zone);
   assign isum_add = pwws_pkg::sat32(50'(integ_ff) + 50'(err));
   assign isum_a33 = pwws_pkg::clamp_mag(in_zone ? 33'(isum_add) : 33'sd0,
                                          cfg.integ_limit);
   assign isum_a   = isum_a33[31:0];
   assign isum_b_sat = pwws_pkg::sat32(50'(isum_a) - 50'(err));
   assign isum_b33   = pwws_pkg::clamp_mag(33'(isum_b_sat), cfg.integ_limit);
   assign isum_b     = isum_b33[31:0];

   // Gain products; both integral candidates are weighted in parallel.
   assign prod_p  = 32'(cfg.prop_gain) * 32'(err);
   assign prod_d  = 33'(cfg.deriv_gain) * der;
   assign prod_ia = 48'(cfg.integ_gain) * 48'(isum_a);
   assign prod_ib = 48'(cfg.integ_gain) * 48'(isum_b);

   // Weighted sums, floor shift by 8 and saturation.
   assign sum_a   = 50'(prod_p) + 50'(prod_d) + 50'(prod_ia);
   assign sum_b   = 50'(prod_p) + 50'(prod_d) + 50'(prod_ib);
   assign drive_a = pwws_pkg::sat32(sum_a >>> 8);
   assign drive_b = pwws_pkg::sat32(sum_b >>> 8);

   // Output limit selects the back-calculated result and clamps it.
   assign olim      = $signed({2'b00, cfg.out_limit});
   assign over      = (cfg.out_limit != '0) &&
                      ((33'(drive_a) > olim) || (33'(drive_a) < -olim));
   assign drive_b33 = pwws_pkg::clamp_mag(33'(drive_b), cfg.out_limit);
   assign drive_lim = over ? drive_b33[31:0] : drive_a;

   // Slew limit around the previous drive.
   assign slew33  = $signed({2'b00, cfg.slew_step});
   assign slew_lo = 33'(last_drive_ff) - slew33;
   assign slew_hi = 33'(last_drive_ff) + slew33;
   always_comb begin
      drive_sl = 33'(drive_lim);
      if (cfg.slew_step != '0) begin
         if (33'(drive_lim) < slew_lo) begin
            drive_sl = slew_lo;
         end else if (33'(drive_lim) > slew_hi) begin
            drive_sl = slew_hi;
         end
      end
   end
   assign drive_run = drive_sl[31:0];

   // Result drive and next state.
   assign drive         = is_clear ? 32'sd0 : drive_run;
   assign last_drive_in = drive;
   assign integ_in      = is_clear ? 32'sd0 : (over ? isum_b : isum_a);

   // State registers advance once per item.
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff      <= '0;
         last_err_ff   <= '0;
         have_last_ff  <= 1'b0;
         last_drive_ff <= '0;
      end else if (step) begin
         integ_ff      <= integ_in;
         last_err_ff   <= is_clear ? 16'sd0 : err;
         have_last_ff  <= !is_clear;
         last_drive_ff <= last_drive_in;
      end
   end

   assign integ_sum = integ_ff;

endmodule

// ===== src/pid_with_windup_and_slew_core.sv =====
// Top level of the PID controller with integral zone, anti-windup and slew limit.
// Depends on pwws_pkg, pwws_req_if, pwws_rsp_if, pwws_csr and pwws_datapath.
//
//   Channel   Direction  Handshake          Payload
//   req_chan  in         valid / ready      func, setpoint, actual
//   rsp_chan  out        valid / ready      drive, settled
//   csr_*     in         csr_we, no ready   csr_index, csr_wdata
//
// One item per cycle sustained while the result sink is ready; an accepted item passes
// through the input register, then one arithmetic pass, into the result register.
// The controller state loop (integral, last error, last drive) closes in that pass.
// Reset is synchronous and clears the state and loads the register defaults.
// A stalled result holds in place while one more item waits in the input register.
module pid_with_windup_and_slew_core (
   input  logic                            clock,
   input  logic                            reset,
   pwws_req_if.sink                        req_chan,
   pwws_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [pwws_pkg::IndexWidth-1:0] csr_index,
   input  logic [pwws_pkg::CsrWidth-1:0]   csr_wdata
);

   pwws_pkg::cfg_type cfg;

   // Input register.
   logic                                    in_valid_ff, in_valid_in;
   logic                                    in_func_ff;
   logic signed [pwws_pkg::SampleWidth-1:0] in_sp_ff;
   logic signed [pwws_pkg::SampleWidth-1:0] in_act_ff;

   // Result register.
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [pwws_pkg::DriveWidth-1:0]  rsp_drive_ff;
   logic                                    rsp_settled_ff;

   logic                                    req_take;
   logic                                    advance;
   logic signed [pwws_pkg::DriveWidth-1:0]  dp_drive;
   logic                                    dp_settled;
   logic signed [pwws_pkg::DriveWidth-1:0]  dp_integ;

   pwws_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pwws_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (advance),
      .func      (in_func_ff),
      .setpoint  (in_sp_ff),
      .actual    (in_act_ff),
      .drive     (dp_drive),
      .settled   (dp_settled),
      .integ_sum (dp_integ)
   );

   // An item moves to the result register when that register is free or drains.
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_chan.func;
         in_sp_ff   <= req_chan.setpoint;
         in_act_ff  <= req_chan.actual;
      end
      if (advance) begin
         rsp_drive_ff   <= dp_drive;
         rsp_settled_ff <= dp_settled;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.drive   = rsp_drive_ff;
   assign rsp_chan.settled = rsp_settled_ff;

   // A clear item always produces a zero drive.
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && in_func_ff) |=> (rsp_drive_ff == '0))
      else $error("clear item produced nonzero drive");

   // The integral stays within the clamp that was in force for the item.
   a_integ_clamp: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_func_ff && ($past(1'b1) || 1'b1) && cfg.integ_limit != '0) |=>
      ((33'(dp_integ) <= $signed({2'b00, $past(cfg.integ_limit)})) &&
       (33'(dp_integ) >= -$signed({2'b00, $past(cfg.integ_limit)}))))
      else $error("integral outside its limit");

   // Every item that leaves the input register shows up as a result.
   a_advance_valid: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item did not reach the result register");

   // An empty input register always takes a new item.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_chan.ready)
      else $error("input register empty but not ready");

   // A held result keeps its payload while the sink stalls.
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> $stable(rsp_drive_ff))
      else $error("stalled result changed");

endmodule
